@@ rtl/core/csc_pkg.sv @@
// Shared constants, types and the arctangent table of the CORDIC sine/cosine core.
package csc_pkg;

   // Datapath widths: x/y grow to about 2^31, z stays within +/-2^30.
   localparam int XY_W = 34;
   localparam int Z_W  = 33;
   localparam int OUT_W = 32;

   typedef logic signed [XY_W-1:0]  xy_type;
   typedef logic signed [Z_W-1:0]   z_type;
   typedef logic        [31:0]      phase_type;
   typedef logic signed [OUT_W-1:0] out_type;

   // Octant flags carried along the pipe with each request.
   typedef struct packed {
      logic swap;
      logic neg_cos;
      logic neg_sin;
   } fold_type;

   localparam phase_type HALF_TURN    = 32'h8000_0000;
   localparam phase_type QUARTER_TURN = 32'h4000_0000;
   localparam phase_type EIGHTH_TURN  = 32'h2000_0000;

   localparam xy_type START_GAIN = XY_W'(64'sd1844227466);
   localparam xy_type MAX_MAG    = XY_W'(64'sd2147483647);

   // atan(2^-i) in units of 2^-32 turn.
   function automatic z_type atan_units(input logic [4:0] idx);
      z_type r;
      case (idx)
         5'd0:  r = Z_W'(536870912);
         5'd1:  r = Z_W'(316933406);
         5'd2:  r = Z_W'(167458907);
         5'd3:  r = Z_W'(85004756);
         5'd4:  r = Z_W'(42667331);
         5'd5:  r = Z_W'(21354465);
         5'd6:  r = Z_W'(10679838);
         5'd7:  r = Z_W'(5340245);
         5'd8:  r = Z_W'(2670163);
         5'd9:  r = Z_W'(1335087);
         5'd10: r = Z_W'(667544);
         5'd11: r = Z_W'(333772);
         5'd12: r = Z_W'(166886);
         5'd13: r = Z_W'(83443);
         5'd14: r = Z_W'(41722);
         5'd15: r = Z_W'(20861);
         5'd16: r = Z_W'(10430);
         5'd17: r = Z_W'(5215);
         5'd18: r = Z_W'(2608);
         5'd19: r = Z_W'(1304);
         5'd20: r = Z_W'(652);
         5'd21: r = Z_W'(326);
         5'd22: r = Z_W'(163);
         5'd23: r = Z_W'(81);
         5'd24: r = Z_W'(41);
         5'd25: r = Z_W'(20);
         5'd26: r = Z_W'(10);
         5'd27: r = Z_W'(5);
         5'd28: r = Z_W'(3);
         5'd29: r = Z_W'(1);
         5'd30: r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/cordic_sine_cosine.sv @@
// Pipelined CORDIC sine/cosine generator: binary angle in, cosine and sine out.
//
// One angle request per cycle goes in and one cosine/sine result per cycle
// comes out. The angle (a full turn is 2^ANGLE_BITS) is folded into the
// first octant in the first stage, then each of the TABLE_ENTRIES-1 rotation
// steps has a register stage of its own (one shift-add on x, y and z), and a
// last stage saturates both values to +/-2147483647 and applies the octant
// swap and signs. A request passes the fold, rotation and output registers
// on its way to rsp_*. The whole pipe advances together; it halts only
// while a result sits on the output and rsp_stall is high, and then req_stall
// is raised, so nothing is dropped or repeated. Results come out in request
// order. Reset clears only the valid bits.
module cordic_sine_cosine #(
   parameter int TABLE_ENTRIES = 11,
   parameter int ANGLE_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ANGLE_BITS-1:0]         req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [csc_pkg::OUT_W-1:0] rsp_cos_value,
   output logic signed [csc_pkg::OUT_W-1:0] rsp_sin_value
);
   import csc_pkg::*;

   // Number of rotation stages; stage 0 holds the folded angle.
   localparam int ITERS = TABLE_ENTRIES - 1;

   logic advance;

   // Pipe registers, index k = state after k rotations.
   logic [ITERS:0] valid_ff;
   logic [ITERS:0] valid_in;
   xy_type   x_ff    [0:ITERS];
   xy_type   x_in    [0:ITERS];
   xy_type   y_ff    [0:ITERS];
   xy_type   y_in    [0:ITERS];
   z_type    z_ff    [0:ITERS];
   z_type    z_in    [0:ITERS];
   fold_type fold_ff [0:ITERS];
   fold_type fold_in [0:ITERS];

   logic    rsp_valid_ff, rsp_valid_in;
   out_type rsp_cos_ff, rsp_cos_in;
   out_type rsp_sin_ff, rsp_sin_in;

   // The pipe moves unless a finished result is being held back.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ---------------- Stage 0: octant fold ----------------
   phase_type u0, u1, u2, phase;
   logic      past_half, past_quarter, upper_octant;

   always_comb begin
      u0           = 32'(req_angle) << (32 - ANGLE_BITS);
      past_half    = u0 > HALF_TURN;
      u1           = past_half ? (u0 - HALF_TURN) : u0;
      past_quarter = u1 > QUARTER_TURN;
      u2           = past_quarter ? (HALF_TURN - u1) : u1;
      upper_octant = u2 > EIGHTH_TURN;
      phase        = upper_octant ? (QUARTER_TURN - u2) : u2;

      valid_in[0]        = req_valid;
      x_in[0]            = START_GAIN;
      y_in[0]            = '0;
      z_in[0]            = {1'b0, phase};
      fold_in[0].swap    = upper_octant;
      fold_in[0].neg_cos = past_half ^ past_quarter;
      fold_in[0].neg_sin = past_half;
   end

   // ---------------- Rotation stages ----------------
   for (genvar k = 1; k <= ITERS; k++) begin : g_rot
      xy_type xs, ys;
      logic   ccw;
      always_comb begin
         xs  = x_ff[k-1] >>> k;
         ys  = y_ff[k-1] >>> k;
         // a residual of zero counts as not positive and rotates clockwise
         ccw = !z_ff[k-1][Z_W-1] && (z_ff[k-1] != '0);
         valid_in[k] = valid_ff[k-1];
         fold_in[k]  = fold_ff[k-1];
         if (ccw) begin
            z_in[k] = z_ff[k-1] - atan_units(5'(k));
            x_in[k] = x_ff[k-1] - ys;
            y_in[k] = y_ff[k-1] + xs;
         end else begin
            z_in[k] = z_ff[k-1] + atan_units(5'(k));
            x_in[k] = x_ff[k-1] + ys;
            y_in[k] = y_ff[k-1] - xs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         fold_ff <= fold_in;
      end
   end

   // ---------------- Output stage: saturate, swap, sign ----------------
   function automatic out_type clamp_mag(input xy_type v);
      out_type r;
      if (v > MAX_MAG) begin
         r = OUT_W'(MAX_MAG);
      end else if (v < -MAX_MAG) begin
         r = -OUT_W'(MAX_MAG);
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

   out_type cx, cy, cos_pre, sin_pre;

   always_comb begin
      cx      = clamp_mag(x_ff[ITERS]);
      cy      = clamp_mag(y_ff[ITERS]);
      cos_pre = fold_ff[ITERS].swap ? cy : cx;
      sin_pre = fold_ff[ITERS].swap ? cx : cy;
      rsp_valid_in = valid_ff[ITERS];
      rsp_cos_in   = fold_ff[ITERS].neg_cos ? -cos_pre : cos_pre;
      rsp_sin_in   = fold_ff[ITERS].neg_sin ? -sin_pre : sin_pre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cos_ff <= rsp_cos_in;
         rsp_sin_ff <= rsp_sin_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cos_value = rsp_cos_ff;
   assign rsp_sin_value = rsp_sin_ff;

`ifndef SYNTHESIS
   // saturation happens before negation, so -2^31 never shows up
   a_no_min_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cos_value != {1'b1, {(OUT_W-1){1'b0}}}) &&
                    (rsp_sin_value != {1'b1, {(OUT_W-1){1'b0}}}))
      else $error("result hit -2^31");

   // folded angle never leaves the first octant
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (z_ff[0] <= Z_W'(EIGHTH_TURN)))
      else $error("fold stage angle outside first octant");

   // a held result freezes the valid bit of every fold and rotation stage
   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipe moved while output held");

   // back-pressure only when a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined CORDIC sine/cosine core.
module tb_top;
   import csc_pkg::*;

   localparam int TABLE_ENTRIES = 11;
   localparam int ANGLE_BITS    = 32;
   // Register depth of the core from request to result; sizes the final drain wait.
   localparam int LATENCY       = TABLE_ENTRIES + 1;
   // Watchdog limit on the total run length, with ample margin.
   localparam int CYCLE_LIMIT   = 200000;

   // Rotation vector starts at the prescaled gain; results clamp to this.
   localparam longint GAIN_START = 64'sd1844227466;
   localparam longint MAG_LIMIT  = 64'sd2147483647;

   // atan(2^-i) in units of 2^-32 turn; entry 0 is never used by a rotation.
   localparam longint ATAN_STEP [TABLE_ENTRIES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544
   };

   // Directed angles: both ends of the range, every quadrant boundary with its
   // neighbors, the other octant boundaries, alternating bit patterns and one more.
   localparam logic [31:0] EDGE_ANGLES [22] = '{
      32'h0000_0000, 32'h0000_0001, 32'h1FFF_FFFF, 32'h2000_0000,
      32'h2000_0001, 32'h3FFF_FFFF, 32'h4000_0000, 32'h4000_0001,
      32'h6000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'hA000_0000, 32'hBFFF_FFFF, 32'hC000_0000, 32'hC000_0001,
      32'hE000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h1234_5678
   };

   // One pending request; drain makes the sender hold it back until every
   // outstanding result has come back.
   typedef struct {
      logic [31:0] angle;
      bit          drain;
   } angle_item_type;

   typedef struct {
      logic [31:0] angle;
      out_type     cos_v;
      out_type     sin_v;
   } trig_pair_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   logic [ANGLE_BITS-1:0] req_angle = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   out_type rsp_cos_value;
   out_type rsp_sin_value;

   angle_item_type angle_queue [$];
   trig_pair_type  trig_queue [$];

   int send_idle_pct  = 30;
   int recv_stall_pct = 53;
   int error_count    = 0;
   int cycle_count    = 0;

   cordic_sine_cosine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cos_value (rsp_cos_value),
      .rsp_sin_value (rsp_sin_value)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint clamp_mag(input longint v);
      if (v > MAG_LIMIT) return MAG_LIMIT;
      if (v < -MAG_LIMIT) return -MAG_LIMIT;
      return v;
   endfunction

   // Rotate (GAIN_START, 0) by a phase within the first octant.
   // >>> on a signed longint rounds toward minus infinity, as required.
   function automatic void rotate_octant(input logic [31:0] phase,
                                         output longint xo, output longint yo);
      longint z, x, y, xs, ys;
      z = longint'({32'd0, phase});
      x = GAIN_START;
      y = 0;
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         // residual zero counts as not positive: clockwise
         if (z > 0) begin
            z = z - ATAN_STEP[i];
            x = x - ys;
            y = y + xs;
         end else begin
            z = z + ATAN_STEP[i];
            x = x + ys;
            y = y - xs;
         end
      end
      xo = clamp_mag(x);
      yo = clamp_mag(y);
   endfunction

   function automatic trig_pair_type predict_trig(input logic [31:0] angle);
      trig_pair_type r;
      logic [31:0]   u;
      bit            neg_c, neg_s;
      longint        c, s;
      u     = angle;
      neg_c = 1'b0;
      neg_s = 1'b0;
      // past a half turn: subtract it, both signs flip
      if (u > HALF_TURN) begin
         u     = u - HALF_TURN;
         neg_c = 1'b1;
         neg_s = 1'b1;
      end
      // second quadrant: mirror, cosine flips
      if (u > QUARTER_TURN) begin
         u     = HALF_TURN - u;
         neg_c = !neg_c;
      end
      // second octant: mirror about 1/8 turn and swap the outputs
      if (u <= EIGHTH_TURN)
         rotate_octant(u, c, s);
      else
         rotate_octant(QUARTER_TURN - u, s, c);
      if (neg_c) c = -c;
      if (neg_s) s = -s;
      r.angle = angle;
      r.cos_v = c[31:0];
      r.sin_v = s[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Half fully random, the rest clustered at octant boundaries or just
   // past an octant start, where folding and saturation are exercised.
   function automatic logic [31:0] pick_angle();
      case ($urandom_range(3))
         0: return (32'($urandom_range(7)) << 29) + 32'($urandom_range(64)) - 32'd32;
         1: return (32'($urandom_range(7)) << 29) | 32'($urandom_range(65535));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] angle,
                                  input out_type got, input out_type want);
      error_count++;
      $display("mismatch %s: angle=%h got=%0d expected=%0d", what, angle, got, want);
   endtask

   // Queue one block of random requests under a given idling mix and wait
   // until the sender has handed all of them over. One request in the middle
   // is held back until the pipe is empty.
   task automatic run_phase(input int send_pct, input int stall_pct, input int count);
      angle_item_type item;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         item.angle = pick_angle();
         item.drain = (n == count / 2);
         angle_queue.push_back(item);
      end
      while (angle_queue.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents requests from angle_queue, holds them while stalled,
   // and records the predicted result of each accepted request.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      angle_item_type item;
      bit             slot_free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         slot_free = !req_valid || !req_stall;
         if (req_valid && !req_stall)
            trig_queue.push_back(predict_trig(req_angle));
         if (slot_free) begin
            if (angle_queue.size() != 0
                && !(angle_queue[0].drain && trig_queue.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               item      = angle_queue.pop_front();
               req_valid <= 1'b1;
               req_angle <= item.angle;
            end else begin
               // idle cycle: payload is noise the core must ignore
               req_valid <= 1'b0;
               req_angle <= $urandom;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, and field-by-field check of each
   // accepted result against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      trig_pair_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (trig_queue.size() == 0) begin
               report_mismatch("unexpected result", 32'd0, rsp_cos_value, '0);
            end else begin
               want = trig_queue.pop_front();
               if (rsp_cos_value !== want.cos_v)
                  report_mismatch("cos_value", want.angle, rsp_cos_value, want.cos_v);
               if (rsp_sin_value !== want.sin_v)
                  report_mismatch("sin_value", want.angle, rsp_sin_value, want.sin_v);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      angle_item_type item;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed requests go first, under the first idling mix
      item.drain = 1'b0;
      foreach (EDGE_ANGLES[k]) begin
         item.angle = EDGE_ANGLES[k];
         angle_queue.push_back(item);
      end

      // sender idles lightly, receiver stalls heavily; then swapped; then
      // a stretch at full rate in both directions
      run_phase(30, 53, 210);
      run_phase(53, 30, 210);
      run_phase(0, 0, 210);

      // let the last request get accepted and every result drain out
      while (req_valid || trig_queue.size() != 0) @(posedge clock);
      repeat (3 * LATENCY) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/csc_pkg.sv
rtl/core/cordic_sine_cosine.sv
verif/tb_top.sv
